// ===== rtl/core/spo_osc_pkg.sv =====
// Shared constants, types and the sine table builder for the stereo oscillator.
package spo_osc_pkg;

   localparam int TABLE_ADDRESS_BITS = 10;
   localparam int SAMPLE_BITS        = 16;
   localparam int TABLE_SIZE         = 1 << TABLE_ADDRESS_BITS;

   localparam int PHASE_BITS  = 32;
   localparam int TARGET_BITS = 31;
   localparam int VOLUME_BITS = 16;
   localparam int OUT_BITS    = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [VOLUME_BITS-1:0] VOLUME_RESET = VOLUME_BITS'(6554);

   // One-pole glide: 0.05 in Q0.16.
   localparam int GLIDE_COEF_BITS  = 13;
   localparam int GLIDE_SHIFT      = 16;
   localparam int GLIDE_DIFF_BITS  = PHASE_BITS + 1;
   localparam int GLIDE_PROD_BITS  = GLIDE_DIFF_BITS + GLIDE_COEF_BITS;
   localparam logic signed [GLIDE_COEF_BITS-1:0] GLIDE_COEF = GLIDE_COEF_BITS'(3277);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_INCREMENT   = 2'd0,
      CSR_RIGHT_PHASE_OFFSET = 2'd1,
      CSR_OUTPUT_VOLUME      = 2'd2
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sine_rom_type [TABLE_SIZE];

   // Taylor series of sine through x^15 in Q30, Horner form, truncating each step.
   function automatic longint unsigned sine_q30(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned term;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 7; k++) begin
         term = (x2 * t) >> 30;
         case (k)
            0:       term = term / 210;
            1:       term = term / 156;
            2:       term = term / 110;
            3:       term = term / 72;
            4:       term = term / 42;
            5:       term = term / 20;
            default: term = term / 6;
         endcase
         t = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
      end
      return (x * t) >> 30;
   endfunction

   // Quarter-wave table sampled at the centers of its cells.
   function automatic sine_rom_type sine_rom_build();
      sine_rom_type    rom;
      longint unsigned amp;
      longint unsigned x;
      longint unsigned s;
      longint unsigned v;
      amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         x = (HALF_PI_Q30 * (64'(2 * i) + 64'd1)) >> (TABLE_ADDRESS_BITS + 1);
         s = sine_q30(x);
         v = (s * amp + (64'd1 << 29)) >> 30;
         if (v > amp) begin
            v = amp;
         end
         rom[i] = SAMPLE_BITS'(v);
      end
      return rom;
   endfunction

endpackage

// ===== rtl/core/stereo_phase_offset_sine_oscillator_core.sv =====
// Stereo sine oscillator core: glide, phase accumulator, quarter-wave lookup and volume scaling.
// Each request is one sample tick and produces one stereo response through the phase, table and
// output registers; one request is taken per clock while the response side keeps up, except as
// below. The glide step is precomputed by a registered multiplier from the current increment, so
// a tick that starts a block is held back when it directly follows another block-start tick or a
// write of the target increment, and directly after reset. The sine table is a
// 2^TABLE_ADDRESS_BITS entry ROM with two registered read ports, one per channel; each
// pipeline stage holds its data while the next one is full and not moving.
module stereo_phase_offset_sine_oscillator_core
   import spo_osc_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_first_in_block,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [OUT_BITS-1:0]       rsp_left_sample,
   output logic signed [OUT_BITS-1:0]       rsp_right_sample,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [CSR_DATA_BITS-1:0]         csr_wdata
);

   localparam sine_rom_type SINE_ROM = sine_rom_build();
   localparam int PROD_BITS = SAMPLE_BITS + VOLUME_BITS + 1;

   logic [TARGET_BITS-1:0]  target_ff;
   logic [PHASE_BITS-1:0]   offset_ff;
   logic [VOLUME_BITS-1:0]  volume_ff;

   logic [PHASE_BITS-1:0]   phase_ff;
   logic [PHASE_BITS-1:0]   phase_in;
   logic [PHASE_BITS-1:0]   incr_ff;
   logic [PHASE_BITS-1:0]   incr_in;
   logic [PHASE_BITS-1:0]   step_ff;
   logic [PHASE_BITS-1:0]   step_in;
   logic                    step_ok_ff;

   logic signed [GLIDE_DIFF_BITS-1:0] glide_diff;
   logic signed [GLIDE_PROD_BITS-1:0] glide_prod;

   logic                    v1_ff;
   logic                    v2_ff;
   logic                    v3_ff;
   logic                    en1;
   logic                    en2;
   logic                    en3;
   logic                    req_fire;
   logic                    csr_fire;
   logic                    glide_now;

   logic [PHASE_BITS-1:0]         ph1_ff;
   logic [PHASE_BITS-1:0]         ph_right;
   logic [TABLE_ADDRESS_BITS-1:0] addr_l;
   logic [TABLE_ADDRESS_BITS-1:0] addr_r;

   logic signed [SAMPLE_BITS-1:0] rom_l_ff;
   logic signed [SAMPLE_BITS-1:0] rom_r_ff;
   logic                          neg_l_ff;
   logic                          neg_r_ff;

   logic signed [SAMPLE_BITS-1:0] sine_l;
   logic signed [SAMPLE_BITS-1:0] sine_r;
   logic signed [PROD_BITS-1:0]   prod_l;
   logic signed [PROD_BITS-1:0]   prod_r;
   logic signed [OUT_BITS-1:0]    left_ff;
   logic signed [OUT_BITS-1:0]    right_ff;

   // Handshakes. Each stage moves when the one after it is empty or moving.
   assign en3       = !v3_ff || rsp_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1 && (step_ok_ff || !req_first_in_block);
   assign req_fire  = req_valid && req_ready;
   assign glide_now = req_fire && req_first_in_block;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         offset_ff <= '0;
         volume_ff <= VOLUME_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_TARGET_INCREMENT:   target_ff <= csr_wdata[TARGET_BITS-1:0];
            CSR_RIGHT_PHASE_OFFSET: offset_ff <= csr_wdata[PHASE_BITS-1:0];
            CSR_OUTPUT_VOLUME:      volume_ff <= csr_wdata[VOLUME_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Glide step from the registered increment; floor of diff * 3277 / 65536.
   always_comb begin
      glide_diff = $signed({2'b00, target_ff}) - $signed({1'b0, incr_ff});
      glide_prod = glide_diff * GLIDE_COEF;
      step_in    = PHASE_BITS'(glide_prod >>> GLIDE_SHIFT);
   end

   always_comb begin
      incr_in  = glide_now ? incr_ff + step_ff : incr_ff;
      phase_in = phase_ff + incr_in;
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   // The step register is marked stale in the cycle after the increment or target changes.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ok_ff <= 1'b0;
         incr_ff    <= '0;
         phase_ff   <= '0;
      end else begin
         step_ok_ff <= !(glide_now || (csr_fire && csr_index == CSR_TARGET_INCREMENT));
         if (req_fire) begin
            incr_ff  <= incr_in;
            phase_ff <= phase_in;
         end
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_fire;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ph1_ff <= phase_in;
      end
   end

   // Quarter-wave addressing: odd quadrants read the table mirrored.
   always_comb begin
      ph_right = ph1_ff + offset_ff;
      addr_l   = ph1_ff[PHASE_BITS-3 -: TABLE_ADDRESS_BITS];
      addr_r   = ph_right[PHASE_BITS-3 -: TABLE_ADDRESS_BITS];
      if (ph1_ff[PHASE_BITS-2]) begin
         addr_l = ~addr_l;
      end
      if (ph_right[PHASE_BITS-2]) begin
         addr_r = ~addr_r;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rom_l_ff <= SINE_ROM[addr_l];
         rom_r_ff <= SINE_ROM[addr_r];
         neg_l_ff <= ph1_ff[PHASE_BITS-1];
         neg_r_ff <= ph_right[PHASE_BITS-1];
      end
   end

   // Sign for the lower half turn, then floor(sine * volume / 2^SAMPLE_BITS).
   always_comb begin
      sine_l = neg_l_ff ? -rom_l_ff : rom_l_ff;
      sine_r = neg_r_ff ? -rom_r_ff : rom_r_ff;
      prod_l = PROD_BITS'(sine_l) * $signed({1'b0, volume_ff});
      prod_r = PROD_BITS'(sine_r) * $signed({1'b0, volume_ff});
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         left_ff  <= prod_l[SAMPLE_BITS +: OUT_BITS];
         right_ff <= prod_r[SAMPLE_BITS +: OUT_BITS];
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_left_sample  = left_ff;
   assign rsp_right_sample = right_ff;

   property p_glide_uses_fresh_step;
      @(posedge clock) disable iff (reset)
         glide_now |-> step_ok_ff;
   endproperty
   a_glide_uses_fresh_step: assert property (p_glide_uses_fresh_step)
      else $error("block-start request accepted with a stale glide step");

   property p_glide_marks_step_stale;
      @(posedge clock) disable iff (reset)
         glide_now |=> !step_ok_ff;
   endproperty
   a_glide_marks_step_stale: assert property (p_glide_marks_step_stale)
      else $error("glide step not invalidated after an increment update");

   property p_plain_tick_keeps_increment;
      @(posedge clock) disable iff (reset)
         req_fire && !req_first_in_block |=> $stable(incr_ff);
   endproperty
   a_plain_tick_keeps_increment: assert property (p_plain_tick_keeps_increment)
      else $error("increment changed on a tick that does not start a block");

   property p_accept_fills_stage;
      @(posedge clock) disable iff (reset)
         req_fire |=> v1_ff;
   endproperty
   a_accept_fills_stage: assert property (p_accept_fills_stage)
      else $error("accepted request lost before the table stage");

   property p_table_nonnegative;
      @(posedge clock) disable iff (reset)
         v2_ff |-> !rom_l_ff[SAMPLE_BITS-1] && !rom_r_ff[SAMPLE_BITS-1];
   endproperty
   a_table_nonnegative: assert property (p_table_nonnegative)
      else $error("quarter-wave table returned a negative entry");

endmodule
